// ----- rtl/ppl_pkg.sv -----
// ppl_pkg: types and constants shared by the parallel port link bridge.
// No dependencies; used by every module of the bridge.
package ppl_pkg;

  // Controller phase, one-hot.
  typedef enum logic [4:0] {
    PH_HEADER    = 5'b00001,
    PH_SEND_DATA = 5'b00010,
    PH_SEND_ACK  = 5'b00100,
    PH_RECV_ACK  = 5'b01000,
    PH_DRAIN     = 5'b10000
  } phase_e;

  // Input word kinds (a pin sample is any other code).
  localparam logic [1:0] KIND_HOST = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Command codes from the header's first byte.
  localparam logic [7:0] OP_TGT_RESET  = 8'd0;
  localparam logic [7:0] OP_STROBE     = 8'd1;
  localparam logic [7:0] OP_ACK_QUERY  = 8'd2;
  localparam logic [7:0] OP_PORT_IN    = 8'd3;
  localparam logic [7:0] OP_PORT_OUT   = 8'd4;
  localparam logic [7:0] OP_PORT_READ  = 8'd5;
  localparam logic [7:0] OP_PORT_WRITE = 8'd6;
  localparam logic [7:0] OP_BLOCK_SEND = 8'd7;
  localparam logic [7:0] OP_BLOCK_RECV = 8'd8;

  localparam logic [3:0] HEADER_LEN = 4'd9;

  localparam logic [7:0] BYTE_ACK_CHANGED = 8'h55;
  localparam logic [7:0] BYTE_ACK_SAME    = 8'haa;
  localparam logic [7:0] BYTE_PAD         = 8'hff;
  localparam logic [7:0] BYTE_PULLUP      = 8'hff;

  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_W       = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] host_byte;
    logic       ack_level;
    logic [7:0] port_in;
  } in_item_t;

  // All results caused by one input word; bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [RES_W-1:0]            n;
    logic                        host_valid;
    logic [7:0]                  port_value;
    logic                        port_drive;
    logic                        strobe;
    logic                        rst;
  } bundle_t;

endpackage

// ----- rtl/ppl_in_if.sv -----
// ppl_in_if: input channel of the bridge, valid/ready plus one input word.
// Standalone; no package dependency.
interface ppl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] host_byte;
  logic       ack_level;
  logic [7:0] port_in;

  modport source (output valid, kind, host_byte, ack_level, port_in, input ready);
  modport sink   (input valid, kind, host_byte, ack_level, port_in, output ready);
endinterface

// ----- rtl/ppl_out_if.sv -----
// ppl_out_if: result channel of the bridge, valid/ready plus one result word.
// Standalone; no package dependency.
interface ppl_out_if;
  logic       valid;
  logic       ready;
  logic       host_valid;
  logic [7:0] host_out;
  logic [7:0] port_value;
  logic       port_drive;
  logic       strobe_pulse;
  logic       reset_pulse;
  logic       last;

  modport source (output valid, host_valid, host_out, port_value, port_drive, strobe_pulse,
                  reset_pulse, last, input ready);
  modport sink   (input valid, host_valid, host_out, port_value, port_drive, strobe_pulse,
                  reset_pulse, last, output ready);
endinterface

// ----- rtl/ppl_ctrl.sv -----
// ppl_ctrl: bridge state registers and the per-word next-state logic.
// Depends on ppl_pkg; produces the result bundle of the word being accepted.
module ppl_ctrl #(
  parameter int unsigned TICKS_PER_SECOND = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ppl_pkg::in_item_t item_i,
  output ppl_pkg::bundle_t  bundle_o
);

  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned LW = 32 + TW;

  ppl_pkg::phase_e phase_q, phase_d;
  logic [3:0]  header_count_q, header_count_d;
  logic [7:0]  command_q, command_d;
  logic [31:0] size_q, size_d;
  logic [31:0] timeout_q, timeout_d;
  logic [31:0] byte_index_q, byte_index_d;
  logic [31:0] tick_q, tick_d;
  logic        last_ack_q, last_ack_d;
  logic [7:0]  drive_value_q, drive_value_d;
  logic        drive_enable_q, drive_enable_d;
  logic [31:0] reported_q, reported_d;
  logic [LW-1:0] limit_q, limit_d;   // timeout in ticks

  logic [31:0] tick_inc;
  logic [31:0] index_inc;
  logic [3:0]  header_inc;
  logic        timed_out;
  logic        toggled;
  logic        put_b0;
  logic [7:0]  b0;
  logic        put_cnt;
  logic        strobe;
  logic        rst;

  assign tick_inc   = tick_q + {31'd0, item_i.kind == ppl_pkg::KIND_TICK};
  assign index_inc  = byte_index_q + 32'd1;
  assign header_inc = header_count_q + 4'd1;
  assign timed_out  = (timeout_q != 32'd0) && ({{TW{1'b0}}, tick_inc} >= limit_q);
  assign toggled    = item_i.ack_level != last_ack_q;
  assign limit_d    = LW'(timeout_d) * LW'(TICKS_PER_SECOND);

  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    command_d      = command_q;
    size_d         = size_q;
    timeout_d      = timeout_q;
    byte_index_d   = byte_index_q;
    tick_d         = tick_inc;
    last_ack_d     = last_ack_q;
    drive_value_d  = drive_value_q;
    drive_enable_d = drive_enable_q;
    reported_d     = reported_q;
    put_b0         = 1'b0;
    b0             = 8'd0;
    put_cnt        = 1'b0;
    strobe         = 1'b0;
    rst            = 1'b0;

    unique case (phase_q)
      ppl_pkg::PH_SEND_DATA: begin
        if (item_i.kind == ppl_pkg::KIND_HOST) begin
          drive_value_d = item_i.host_byte;
          strobe        = 1'b1;
          tick_d        = 32'd0;
          phase_d       = ppl_pkg::PH_SEND_ACK;
        end
      end
      ppl_pkg::PH_SEND_ACK: begin
        if (timed_out) begin
          reported_d = index_inc;
          put_cnt    = 1'b1;
          phase_d    = ppl_pkg::PH_HEADER;
        end else if (toggled) begin
          last_ack_d   = item_i.ack_level;
          byte_index_d = index_inc;
          if (index_inc >= size_q) begin
            put_cnt = 1'b1;
            phase_d = ppl_pkg::PH_HEADER;
          end else begin
            phase_d = ppl_pkg::PH_SEND_DATA;
          end
        end
      end
      ppl_pkg::PH_RECV_ACK: begin
        if (timed_out) begin
          // first padding byte goes out with the word that timed out
          reported_d   = index_inc;
          put_b0       = 1'b1;
          b0           = ppl_pkg::BYTE_PAD;
          byte_index_d = index_inc;
          if (index_inc >= size_q) begin
            put_cnt = 1'b1;
            phase_d = ppl_pkg::PH_HEADER;
          end else begin
            phase_d = ppl_pkg::PH_DRAIN;
          end
        end else if (toggled) begin
          last_ack_d   = item_i.ack_level;
          put_b0       = 1'b1;
          b0           = item_i.port_in;
          strobe       = 1'b1;
          byte_index_d = index_inc;
          tick_d       = 32'd0;
          if (index_inc >= size_q) begin
            put_cnt = 1'b1;
            phase_d = ppl_pkg::PH_HEADER;
          end
        end
      end
      ppl_pkg::PH_DRAIN: begin
        put_b0       = 1'b1;
        b0           = ppl_pkg::BYTE_PAD;
        byte_index_d = index_inc;
        if (index_inc >= size_q) begin
          put_cnt = 1'b1;
          phase_d = ppl_pkg::PH_HEADER;
        end
      end
      default: begin
        // header gathering; unused codes land here too
        phase_d = ppl_pkg::PH_HEADER;
        if (item_i.kind == ppl_pkg::KIND_HOST) begin
          unique case (header_count_q)
            4'd0: command_d = item_i.host_byte;
            4'd1: size_d[7:0] = item_i.host_byte;
            4'd2: size_d[15:8] = item_i.host_byte;
            4'd3: size_d[23:16] = item_i.host_byte;
            4'd4: size_d[31:24] = item_i.host_byte;
            4'd5: timeout_d[7:0] = item_i.host_byte;
            4'd6: timeout_d[15:8] = item_i.host_byte;
            4'd7: timeout_d[23:16] = item_i.host_byte;
            4'd8: timeout_d[31:24] = item_i.host_byte;
            default: ;
          endcase
          header_count_d = header_inc;
          if (header_inc >= ppl_pkg::HEADER_LEN) begin
            header_count_d = 4'd0;
            unique case (command_d)
              ppl_pkg::OP_TGT_RESET: rst = 1'b1;
              ppl_pkg::OP_STROBE:    strobe = 1'b1;
              ppl_pkg::OP_ACK_QUERY: begin
                put_b0 = 1'b1;
                if (toggled) begin
                  last_ack_d = item_i.ack_level;
                  b0         = ppl_pkg::BYTE_ACK_CHANGED;
                end else begin
                  b0 = ppl_pkg::BYTE_ACK_SAME;
                end
              end
              ppl_pkg::OP_PORT_IN: begin
                drive_enable_d = 1'b0;
                drive_value_d  = ppl_pkg::BYTE_PULLUP;
              end
              ppl_pkg::OP_PORT_OUT: drive_enable_d = 1'b1;
              ppl_pkg::OP_PORT_READ: begin
                put_b0 = 1'b1;
                b0     = item_i.port_in;
              end
              ppl_pkg::OP_PORT_WRITE: drive_value_d = size_d[7:0];
              ppl_pkg::OP_BLOCK_SEND, ppl_pkg::OP_BLOCK_RECV: begin
                byte_index_d = 32'd0;
                tick_d       = 32'd0;
                reported_d   = size_d;
                if (size_d == 32'd0) begin
                  put_cnt = 1'b1;
                end else if (command_d == ppl_pkg::OP_BLOCK_SEND) begin
                  phase_d = ppl_pkg::PH_SEND_DATA;
                end else begin
                  phase_d = ppl_pkg::PH_RECV_ACK;
                end
              end
              default: ;
            endcase
          end
        end
      end
    endcase
  end

  // Pack the results: optional data byte, then optional 4-byte count.
  always_comb begin
    bundle_o            = '0;
    bundle_o.port_value = drive_value_d;
    bundle_o.port_drive = drive_enable_d;
    bundle_o.strobe     = strobe;
    bundle_o.rst        = rst;
    if (put_b0) begin
      bundle_o.host_valid = 1'b1;
      bundle_o.bytes[0]   = b0;
      if (put_cnt) begin
        bundle_o.bytes[1] = reported_d[7:0];
        bundle_o.bytes[2] = reported_d[15:8];
        bundle_o.bytes[3] = reported_d[23:16];
        bundle_o.bytes[4] = reported_d[31:24];
        bundle_o.n        = ppl_pkg::RES_W'(5);
      end else begin
        bundle_o.n = ppl_pkg::RES_W'(1);
      end
    end else if (put_cnt) begin
      bundle_o.host_valid = 1'b1;
      bundle_o.bytes[0]   = reported_d[7:0];
      bundle_o.bytes[1]   = reported_d[15:8];
      bundle_o.bytes[2]   = reported_d[23:16];
      bundle_o.bytes[3]   = reported_d[31:24];
      bundle_o.n          = ppl_pkg::RES_W'(4);
    end else begin
      bundle_o.n = ppl_pkg::RES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= ppl_pkg::PH_HEADER;
      header_count_q <= 4'd0;
      command_q      <= 8'd0;
      size_q         <= 32'd0;
      timeout_q      <= 32'd0;
      byte_index_q   <= 32'd0;
      tick_q         <= 32'd0;
      last_ack_q     <= 1'b1;
      drive_value_q  <= 8'd0;
      drive_enable_q <= 1'b0;
      reported_q     <= 32'd0;
      limit_q        <= '0;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      command_q      <= command_d;
      size_q         <= size_d;
      timeout_q      <= timeout_d;
      byte_index_q   <= byte_index_d;
      tick_q         <= tick_d;
      last_ack_q     <= last_ack_d;
      drive_value_q  <= drive_value_d;
      drive_enable_q <= drive_enable_d;
      reported_q     <= reported_d;
      limit_q        <= limit_d;
    end
  end

endmodule

// ----- rtl/ppl_out_stage.sv -----
// ppl_out_stage: two-slot bundle buffer that plays results out one per word.
// Depends on ppl_pkg and ppl_out_if.
module ppl_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ppl_pkg::bundle_t  bundle_i,
  output logic              ready_o,
  ppl_out_if.source         out_o
);

  ppl_pkg::bundle_t          hold_q, play_q;
  logic                      hold_valid_q, play_valid_q;
  logic [ppl_pkg::RES_W-1:0] idx_q;
  logic                      at_last;
  logic                      play_done;
  logic                      play_free;

  assign at_last   = idx_q == (play_q.n - ppl_pkg::RES_W'(1));
  assign play_done = play_valid_q && out_o.ready && at_last;
  assign play_free = !play_valid_q || play_done;
  assign ready_o   = !hold_valid_q;

  assign out_o.valid        = play_valid_q;
  assign out_o.host_valid   = play_q.host_valid;
  assign out_o.host_out     = play_q.bytes[idx_q];
  assign out_o.port_value   = play_q.port_value;
  assign out_o.port_drive   = play_q.port_drive;
  assign out_o.strobe_pulse = play_q.strobe && (idx_q == '0);
  assign out_o.reset_pulse  = play_q.rst && (idx_q == '0);
  assign out_o.last         = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      play_valid_q <= 1'b0;
      idx_q        <= '0;
    end else if (play_free) begin
      idx_q <= '0;
      if (hold_valid_q) begin
        play_valid_q <= 1'b1;
        hold_valid_q <= 1'b0;
      end else begin
        play_valid_q <= push_i;
      end
    end else begin
      if (out_o.ready) begin
        idx_q <= idx_q + ppl_pkg::RES_W'(1);
      end
      if (push_i) begin
        hold_valid_q <= 1'b1;
      end
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (play_free) begin
      if (hold_valid_q) begin
        play_q <= hold_q;
      end else if (push_i) begin
        play_q <= bundle_i;
      end
    end else if (push_i) begin
      hold_q <= bundle_i;
    end
  end

endmodule

// ----- rtl/parallel_port_link_bridge.sv -----
// parallel_port_link_bridge: host byte link to 8-bit parallel port bridge.
// Depends on ppl_pkg, ppl_in_if, ppl_out_if, ppl_ctrl and ppl_out_stage.
//
// Usage:
//   in_i carries one word per handshake: a host byte, a pin sample or a
//   quarter-second timer tick, always with the current ack level and port
//   data. Each accepted word produces one to five result words on out_o;
//   the last of them has last set. host_valid marks result words that carry
//   a byte for the host (data, 0x55/0xaa status, 0xff padding, count bytes).
//   port_value/port_drive give the port state after the word; strobe_pulse
//   and reset_pulse are requests, shown only on the first result word.
//
// Timing:
//   The controller updates its state in the cycle a word is accepted; its
//   result bundle is registered into the play slot, or waits in the extra
//   hold slot while an earlier word still plays out. A word with k results
//   holds the output until all k are taken, so single-result words flow at
//   one per cycle while out_o.ready stays high. in_i.ready drops while the
//   hold slot is full (a multi-result word in progress or a receiver stall)
//   and comes back right after the edge taking the word ahead's last result.
//
// Reset (rst_ni low, async): header gathering, port as input with value 0,
// ack reference level 1, output buffer empty.
module parallel_port_link_bridge #(
  parameter int unsigned TICKS_PER_SECOND = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppl_in_if.sink    in_i,
  ppl_out_if.source out_o
);

  ppl_pkg::in_item_t item;
  ppl_pkg::bundle_t  bundle;
  logic              ready;
  logic              accept;

  assign item.kind      = in_i.kind;
  assign item.host_byte = in_i.host_byte;
  assign item.ack_level = in_i.ack_level;
  assign item.port_in   = in_i.port_in;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  // state machine and per-word result bundle
  ppl_ctrl #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .bundle_o (bundle)
  );

  // bundle buffer and result serializer
  ppl_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .bundle_i (bundle),
    .ready_o  (ready),
    .out_o    (out_o)
  );

endmodule
